// ===== rtl/satq_pkg.sv =====
// Shared types and constants for the sorted alarm timer queue.
package satq_pkg;

    // Operation codes carried by the operation field.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Status codes carried by the status field.
    localparam logic STATUS_EXPIRED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // At most this many expirations are reported for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // latch an insert beat and its expiry time
        logic ins;       // place the latched entry into the sorted table
        logic tick;      // advance the time counter
        logic pop;       // report and remove the head entry
        logic last;      // the popped entry is the final report of the tick
        logic rej;       // report the incoming insert beat as rejected
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;      // table holds the maximum number of entries
        logic head_due;  // head entry exists and has expired
        logic next_due;  // entry behind the head exists and has expired
    } t_sts;

endpackage

// ===== rtl/sorted_alarm_timer_queue.sv =====
// Insert: expiry add at the accepting edge, then busy during sorted placement in the insert state.
// Rejected insert: result strobe in the cycle after the accepting edge; not busy.
// Tick: busy in the drain state until the last due expiration (at most 16) leaves, or until none is found due;
// one result per cycle from the head cell, each popped in the drain state and then registered.
// The receiver cannot stall, so results are never held back.
// Synchronous active-low reset clears the time counter, entry count, result strobe and controller.
module sorted_alarm_timer_queue
    import satq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [15:0] i_delay_seconds,
    input  logic [15:0] i_alarm_tag,
    output logic        o_valid,
    output logic [15:0] o_tag_out,
    output logic [15:0] o_delay_out,
    output logic        o_status,
    output logic        o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of inserts and tick drains.
    satq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    // Sorted entry table and result registers.
    satq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_delay_seconds (i_delay_seconds),
        .i_alarm_tag     (i_alarm_tag),
        .o_sts           (sts),
        .o_tag_out       (o_tag_out),
        .o_delay_out     (o_delay_out),
        .o_status        (o_status),
        .o_last          (o_last),
        .o_valid         (o_valid)
    );

endmodule

// ===== rtl/satq_ctrl.sv =====
// Controller state machine that sequences inserts and tick drains.
module satq_ctrl
    import satq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_operation,
    input  t_sts i_sts,
    output logic busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INSERT = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [RES_CNT_W-1:0] r_nres, n_nres;

    assign busy = (r_state != S_IDLE);

    // Next state, result counter and datapath commands.
    always_comb begin
        n_state = r_state;
        n_nres  = r_nres;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation == OP_INSERT) begin
                        if (i_sts.full) begin
                            o_cmd.rej = 1'b1;
                        end else begin
                            o_cmd.load_in = 1'b1;
                            n_state       = S_INSERT;
                        end
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_nres     = '0;
                        n_state    = S_DRAIN;
                    end
                end
            end
            S_INSERT: begin
                o_cmd.ins = 1'b1;
                n_state   = S_IDLE;
            end
            S_DRAIN: begin
                // One expired head entry leaves per cycle.
                if (i_sts.head_due) begin
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = !i_sts.next_due ||
                                 (r_nres == RES_CNT_W'(MAX_RESULTS - 1));
                    n_nres     = r_nres + 1'b1;
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nres  <= '0;
        end else begin
            r_state <= n_state;
            r_nres  <= n_nres;
        end
    end

endmodule

// ===== rtl/satq_datapath.sv =====
// Datapath with the sorted entry cells, time counter and result registers.
module satq_datapath
    import satq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_delay_seconds,
    input  logic [15:0] i_alarm_tag,
    output t_sts        o_sts,
    output logic [15:0] o_tag_out,
    output logic [15:0] o_delay_out,
    output logic        o_status,
    output logic        o_last,
    output logic        o_valid
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]      r_exp [QUEUE_DEPTH];
    logic [15:0]      r_dly [QUEUE_DEPTH];
    logic [15:0]      r_tag [QUEUE_DEPTH];
    logic [CW-1:0]    r_count;
    logic [31:0]      r_time;
    logic [31:0]      r_new_exp;
    logic [15:0]      r_new_dly;
    logic [15:0]      r_new_tag;

    logic [QUEUE_DEPTH-1:0] lt;
    logic [QUEUE_DEPTH-1:0] take_new;

    // Each cell compares its own expiry with the new one; the earlier cells
    // form a prefix because the table is kept sorted.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && (r_exp[i] < r_new_exp);
        end
        take_new = ~lt & {lt[QUEUE_DEPTH-2:0], 1'b1};
    end

    assign o_sts.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.head_due = (r_count != '0) && (r_exp[0] <= r_time);
    assign o_sts.next_due = (r_count > CW'(1)) && (r_exp[1] <= r_time);

    // Entry cells: insert shifts the later part up, pop shifts all down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (take_new[0]) begin
                r_exp[0] <= r_new_exp;
                r_dly[0] <= r_new_dly;
                r_tag[0] <= r_new_tag;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (take_new[i]) begin
                    r_exp[i] <= r_new_exp;
                    r_dly[i] <= r_new_dly;
                    r_tag[i] <= r_new_tag;
                end else if (!lt[i]) begin
                    r_exp[i] <= r_exp[i-1];
                    r_dly[i] <= r_dly[i-1];
                    r_tag[i] <= r_tag[i-1];
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_exp[i] <= r_exp[i+1];
                r_dly[i] <= r_dly[i+1];
                r_tag[i] <= r_tag[i+1];
            end
        end
    end

    // Latched insert beat with its absolute expiry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_new_exp <= r_time + {16'd0, i_delay_seconds};
            r_new_dly <= i_delay_seconds;
            r_new_tag <= i_alarm_tag;
        end
    end

    // Entry count and time counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
        end else begin
            if (i_cmd.ins) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.tick) begin
                r_time <= r_time + 32'd1;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.pop || i_cmd.rej;
        end
    end

    // Result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rej) begin
            o_tag_out   <= i_alarm_tag;
            o_delay_out <= i_delay_seconds;
            o_status    <= STATUS_REJECTED;
            o_last      <= 1'b1;
        end else if (i_cmd.pop) begin
            o_tag_out   <= r_tag[0];
            o_delay_out <= r_dly[0];
            o_status    <= STATUS_EXPIRED;
            o_last      <= i_cmd.last;
        end
    end

endmodule

// ===== rtl/satq_checker.sv =====
// Port-level checker for the sorted alarm timer queue, bound to the top level.
module satq_checker
    import satq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_operation,
    input logic        o_valid,
    input logic        o_status,
    input logic        o_last
);

    // A rejected insert is always the only result of its beat.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_REJECTED) |-> o_last)
        else $error("rejected insert without last");

    // A result that is not the last one means the drain is still running.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result while idle");

    // A tick beat starts a drain and gives no result in the next cycle.
    a_tick_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_TICK) |=> (busy && !o_valid))
        else $error("tick beat did not start a drain");

    // An insert beat is either placed while busy or rejected at once.
    a_insert_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_INSERT) |=>
            ((busy && !o_valid) ||
             (!busy && o_valid && o_status == STATUS_REJECTED && o_last)))
        else $error("insert beat with unexpected outcome");

endmodule

bind sorted_alarm_timer_queue satq_checker u_satq_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted alarm timer queue: random and directed beats.
module testbench;
    import satq_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 64;

    typedef struct packed {
        logic        op;
        logic [15:0] delay;
        logic [15:0] tag;
    } t_alarm_cmd;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] delay;
        logic        status;
        logic        last;
    } t_alarm_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = OP_TICK;
    logic [15:0] i_delay_seconds = '0;
    logic [15:0] i_alarm_tag = '0;
    logic        o_valid;
    logic [15:0] o_tag_out;
    logic [15:0] o_delay_out;
    logic        o_status;
    logic        o_last;

    // Beats waiting to be sent, and reports the table is expected to produce.
    t_alarm_cmd    cmd_backlog[$];
    t_alarm_report due_reports[$];
    t_alarm_cmd    cmd_on_bus;

    int sender_idle_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Shadow copy of the alarm table.
    logic [31:0] shadow_now = '0;
    logic [31:0] shadow_expiry[TABLE_DEPTH];
    logic [15:0] shadow_delay[TABLE_DEPTH];
    logic [15:0] shadow_tag[TABLE_DEPTH];
    int          shadow_count = 0;

    sorted_alarm_timer_queue #(
        .QUEUE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_delay_seconds(i_delay_seconds),
        .i_alarm_tag    (i_alarm_tag),
        .o_valid        (o_valid),
        .o_tag_out      (o_tag_out),
        .o_delay_out    (o_delay_out),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Apply one accepted beat to the shadow table and queue the reports it causes.
    function automatic void advance_alarm_table(t_alarm_cmd c);
        logic [31:0]   expiry;
        int            pos;
        int            n;
        t_alarm_report rep;
        if (c.op == OP_INSERT) begin
            if (shadow_count >= TABLE_DEPTH) begin
                rep = '{tag: c.tag, delay: c.delay, status: STATUS_REJECTED, last: 1'b1};
                due_reports.push_back(rep);
            end else begin
                expiry = shadow_now + {16'd0, c.delay};
                pos = 0;
                // The new entry lands ahead of every entry expiring at the same time or later.
                while (pos < shadow_count && shadow_expiry[pos] < expiry) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_expiry[i] = shadow_expiry[i - 1];
                    shadow_delay[i]  = shadow_delay[i - 1];
                    shadow_tag[i]    = shadow_tag[i - 1];
                end
                shadow_expiry[pos] = expiry;
                shadow_delay[pos]  = c.delay;
                shadow_tag[pos]    = c.tag;
                shadow_count++;
            end
        end else begin
            shadow_now = shadow_now + 32'd1;
            n = 0;
            while (n < MAX_RESULTS && shadow_count > 0 && shadow_expiry[0] <= shadow_now) begin
                rep = '{tag: shadow_tag[0], delay: shadow_delay[0],
                        status: STATUS_EXPIRED, last: 1'b0};
                due_reports.push_back(rep);
                n++;
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_expiry[i - 1] = shadow_expiry[i];
                    shadow_delay[i - 1]  = shadow_delay[i];
                    shadow_tag[i - 1]    = shadow_tag[i];
                end
                shadow_count--;
            end
            // Mark the final expiration of this tick.
            if (n > 0) begin
                rep = due_reports[due_reports.size() - 1];
                rep.last = 1'b1;
                due_reports[due_reports.size() - 1] = rep;
            end
        end
    endfunction

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(0, 10));
        else if (r < 98) return 16'($urandom_range(11, 60));
        else return 16'($urandom_range(0, 65535));
    endfunction

    task automatic queue_cmd(logic op, logic [15:0] delay, logic [15:0] tag);
        t_alarm_cmd c;
        c = '{op: op, delay: delay, tag: tag};
        cmd_backlog.push_back(c);
    endtask

    // Hold the sender until every expected report has come and the block has settled.
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (cmd_backlog.size() > 0 || start || due_reports.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: a beat is taken when start is high and busy is low at the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                advance_alarm_table(cmd_on_bus);
            end
            if (!start || !busy) begin
                if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    start           <= 1'b1;
                    i_operation     <= cmd_on_bus.op;
                    i_delay_seconds <= cmd_on_bus.delay;
                    i_alarm_tag     <= cmd_on_bus.tag;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed report is checked against the oldest expected one.
    always @(posedge i_clk) begin
        t_alarm_report want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_reports.size() == 0) begin
                log_mismatch($sformatf("unexpected report tag=%h delay=%h status=%b last=%b",
                                       o_tag_out, o_delay_out, o_status, o_last));
            end else begin
                want = due_reports.pop_front();
                if (o_tag_out !== want.tag || o_delay_out !== want.delay ||
                    o_status !== want.status || o_last !== want.last) begin
                    log_mismatch($sformatf(
                        "expected tag=%h delay=%h status=%b last=%b, got %h %h %b %b",
                        want.tag, want.delay, want.status, want.last,
                        o_tag_out, o_delay_out, o_status, o_last));
                end
            end
        end
    end

    // Watchdog on cycles with neither an input beat nor a report.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL sorted_alarm_timer_queue");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: a directed opening, then random phases with different sender idling.
    initial begin
        int idle_by_phase[4];
        int items;
        int burst;
        int tick_run;
        // The receiver cannot hold reports off, so only the sender's idling varies by phase.
        idle_by_phase = '{0, 70, 0, 38};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        // Two zero-delay alarms at the same expiry: the later insert reports first.
        queue_cmd(OP_INSERT, 16'h0000, 16'h0000);
        queue_cmd(OP_INSERT, 16'h0000, 16'hFFFF);
        queue_cmd(OP_TICK, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_TICK, 16'h0000, 16'h0000);
        // Fill the table with one expiry, overflow it, then expire all in one tick.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            queue_cmd(OP_INSERT, 16'd2, 16'(16'h1000 + i));
        end
        queue_cmd(OP_INSERT, 16'hFFFF, 16'hA5A5);
        queue_cmd(OP_TICK, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 16'h0000, 16'h0000);
        drain_and_settle();

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            sender_idle_pct = idle_by_phase[phase];
            items = 0;
            while (items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 2) begin
                    // A burst of near-term alarms that may overflow the table.
                    burst = $urandom_range(8, 18);
                    tick_run = $urandom_range(3, 10);
                    repeat (burst) queue_cmd(OP_INSERT, 16'($urandom_range(0, 8)),
                                             16'($urandom));
                    repeat (tick_run) queue_cmd(OP_TICK, 16'($urandom), 16'($urandom));
                    items += burst + tick_run;
                end else begin
                    if ($urandom_range(0, 1) == 1) begin
                        queue_cmd(OP_INSERT, pick_delay(), 16'($urandom));
                    end else begin
                        queue_cmd(OP_TICK, 16'($urandom), 16'($urandom));
                    end
                    items++;
                end
            end
            drain_and_settle();
        end

        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("PASS sorted_alarm_timer_queue");
        end else begin
            $display("FAIL sorted_alarm_timer_queue");
        end
        $finish;
    end

endmodule
